// ----- hw/rtl/rpn_pkg.sv -----
// rpn_pkg: shared constants, command and status codes, and the request and
// response structs between the calculator sequencer and its arithmetic unit.
// No dependencies.
package rpn_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int AW          = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int FUNC_W      = 4;
    localparam int DEPTH_W     = 6;
    localparam int STAT_W      = 2;
    localparam int STEP_W      = $clog2(DATA_W);

    // command codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH = 4'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD  = 4'd1;
    localparam logic [FUNC_W-1:0] FUNC_SUB  = 4'd2;
    localparam logic [FUNC_W-1:0] FUNC_MUL  = 4'd3;
    localparam logic [FUNC_W-1:0] FUNC_DIV  = 4'd4;
    localparam logic [FUNC_W-1:0] FUNC_DROP = 4'd5;
    localparam logic [FUNC_W-1:0] FUNC_SWAP = 4'd6;
    localparam logic [FUNC_W-1:0] FUNC_DUP  = 4'd7;
    localparam logic [FUNC_W-1:0] FUNC_DUMP = 4'd8;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVER  = 2'd2;
    localparam logic [STAT_W-1:0] ST_DIVZ  = 2'd3;

    // arithmetic unit operations
    localparam logic [1:0] ALU_ADD = 2'd0;
    localparam logic [1:0] ALU_SUB = 2'd1;
    localparam logic [1:0] ALU_MUL = 2'd2;
    localparam logic [1:0] ALU_DIV = 2'd3;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } alu_rsp_t;

    function automatic logic [1:0] alu_op_of(input logic [FUNC_W-1:0] f);
        logic [1:0] op;
        case (f)
            FUNC_ADD: op = ALU_ADD;
            FUNC_SUB: op = ALU_SUB;
            FUNC_MUL: op = ALU_MUL;
            default:  op = ALU_DIV;
        endcase
        return op;
    endfunction

endpackage

// ----- hw/rtl/rpn_alu.sv -----
// rpn_alu: multi-cycle arithmetic unit around one shared 33-bit adder.
// Add/sub in one step, shift-add multiply and restoring divide in 32 steps.
// Depends on rpn_pkg.
module rpn_alu
    import rpn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  alu_req_t          req,
    input  logic [DATA_W-1:0] a,      // top of stack (divisor)
    input  logic [DATA_W-1:0] b,      // second entry (dividend)
    output alu_rsp_t          rsp
);

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_ADD  = 3'd1;
    localparam logic [2:0] A_MUL  = 3'd2;
    localparam logic [2:0] A_DIV  = 3'd3;
    localparam logic [2:0] A_FIX  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] op2_reg, op2_next;
    logic [DATA_W-1:0] qd_reg, qd_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              sub_reg, sub_next;
    logic              neg_reg, neg_next;
    logic              done_reg, done_next;

    logic [DATA_W-1:0] add_x, add_y;
    logic              add_sub;
    logic [DATA_W:0]   add_sum;
    logic [DATA_W-1:0] remsh;
    logic              ge;
    logic              last_step;
    logic [DATA_W-1:0] a_mag, b_mag;

    assign remsh     = {acc_reg[DATA_W-2:0], qd_reg[DATA_W-1]};
    assign last_step = (step_reg == STEP_W'(DATA_W - 1));
    assign a_mag     = a[DATA_W-1] ? (~a + DATA_W'(1)) : a;
    assign b_mag     = b[DATA_W-1] ? (~b + DATA_W'(1)) : b;

    // shared adder operand select
    always_comb
    begin
        add_x   = acc_reg;
        add_y   = op2_reg;
        add_sub = 1'b0;
        case (state_reg)
            A_ADD:
            begin
                add_sub = sub_reg;
            end
            A_DIV:
            begin
                add_x   = remsh;
                add_sub = 1'b1;
            end
            A_FIX:
            begin
                add_x   = '0;
                add_y   = qd_reg;
                add_sub = 1'b1;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_x} + ({1'b0, add_y} ^ {(DATA_W + 1){add_sub}})
                   + (DATA_W + 1)'(add_sub);
    // no borrow out means remsh >= divisor
    assign ge = ~add_sum[DATA_W];

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        op2_next   = op2_reg;
        qd_next    = qd_reg;
        res_next   = res_reg;
        step_next  = step_reg;
        sub_next   = sub_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    step_next = '0;
                    case (req.op)
                        ALU_ADD, ALU_SUB:
                        begin
                            acc_next   = b;
                            op2_next   = a;
                            sub_next   = (req.op == ALU_SUB);
                            state_next = A_ADD;
                        end
                        ALU_MUL:
                        begin
                            acc_next   = '0;
                            op2_next   = b;
                            qd_next    = a;
                            state_next = A_MUL;
                        end
                        default:
                        begin
                            acc_next   = '0;
                            op2_next   = a_mag;
                            qd_next    = b_mag;
                            neg_next   = a[DATA_W-1] ^ b[DATA_W-1];
                            state_next = A_DIV;
                        end
                    endcase
                end
            end
            A_ADD:
            begin
                res_next   = add_sum[DATA_W-1:0];
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            A_MUL:
            begin
                if (qd_reg[0])
                begin
                    acc_next = add_sum[DATA_W-1:0];
                end
                op2_next  = {op2_reg[DATA_W-2:0], 1'b0};
                qd_next   = {1'b0, qd_reg[DATA_W-1:1]};
                step_next = step_reg + STEP_W'(1);
                if (last_step)
                begin
                    res_next   = qd_reg[0] ? add_sum[DATA_W-1:0] : acc_reg;
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
            end
            A_DIV:
            begin
                acc_next  = ge ? add_sum[DATA_W-1:0] : remsh;
                qd_next   = {qd_reg[DATA_W-2:0], ge};
                step_next = step_reg + STEP_W'(1);
                if (last_step)
                begin
                    state_next = A_FIX;
                end
            end
            A_FIX:
            begin
                // negate quotient when operand signs differ
                res_next   = neg_reg ? add_sum[DATA_W-1:0] : qd_reg;
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        op2_reg  <= op2_next;
        qd_reg   <= qd_next;
        res_reg  <= res_next;
        step_reg <= step_next;
        sub_reg  <= sub_next;
        neg_reg  <= neg_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

// ----- hw/rtl/rpn_stack_calculator.sv -----
// rpn_stack_calculator: top level; command sequencer, operand stack memory
// and registered result stage. Depends on rpn_pkg and rpn_alu.
//
// Reverse Polish calculator on a 32-entry stack of 32-bit values. Each
// request on the input channel is one command (func, operand); each command
// returns one status result with the new top value, depth and status, except
// dump, which returns every entry from top to bottom with last set on the
// bottom one (one result with value 0 when the stack is empty). Underflow,
// overflow and divide by zero leave the stack untouched. The block takes one
// command at a time: in_ready is high only while the sequencer is idle, but a
// new command may be taken while the previous result still sits in the
// output register. Mul and div run through the 32 steps of the shared
// add/subtract unit; dump reads the entries one at a time through the single
// registered read port of the stack memory. No clearing pass is needed after
// reset: the depth counter alone marks valid entries.
module rpn_stack_calculator
    import rpn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FUNC_W-1:0]  func,
    input  logic signed [DATA_W-1:0] operand,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [DATA_W-1:0] value,
    output logic [DEPTH_W-1:0] depth,
    output logic [STAT_W-1:0]  status,
    output logic               last
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;  // memory read in flight
    localparam logic [2:0] S_EXEC = 3'd2;  // read data available
    localparam logic [2:0] S_ALU  = 3'd3;
    localparam logic [2:0] S_SWAP = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] top_reg, top_next;    // copy of mem[cnt-1]
    logic [FUNC_W-1:0] func_reg, func_next;
    logic [STAT_W-1:0] stat_reg, stat_next;
    logic [AW-1:0]     rd_addr_reg, rd_addr_next;
    logic [DATA_W-1:0] rd_data_reg;

    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  value_reg, value_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic               last_reg, last_next;

    logic [DATA_W-1:0] mem [STACK_DEPTH];
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    logic [CNT_W-1:0]  cnt_m1, cnt_m2;
    logic              full, slot_free;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    assign cnt_m1    = cnt_reg - CNT_W'(1);
    assign cnt_m2    = cnt_reg - CNT_W'(2);
    assign full      = (cnt_reg == CNT_W'(STACK_DEPTH));
    assign slot_free = ~out_valid_reg | out_ready;
    assign in_ready  = (state_reg == S_IDLE);

    rpn_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .a     (top_reg),
        .b     (rd_data_reg),
        .rsp   (alu_rsp)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        top_next       = top_reg;
        func_next      = func_reg;
        stat_next      = stat_reg;
        rd_addr_next   = rd_addr_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        value_next     = value_reg;
        depth_next     = depth_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg[AW-1:0];
        mem_wdata      = top_reg;
        alu_req.start  = 1'b0;
        alu_req.op     = alu_op_of(func_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    stat_next  = ST_OK;
                    state_next = S_EMIT;
                    case (func)
                        FUNC_PUSH:
                        begin
                            if (full)
                            begin
                                stat_next = ST_OVER;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = operand;
                                top_next  = operand;
                                cnt_next  = cnt_reg + CNT_W'(1);
                            end
                        end
                        FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV, FUNC_SWAP:
                        begin
                            if (cnt_reg < CNT_W'(2))
                            begin
                                stat_next = ST_UNDER;
                            end
                            else if (func == FUNC_DIV && top_reg == '0)
                            begin
                                stat_next = ST_DIVZ;
                            end
                            else
                            begin
                                rd_addr_next = cnt_m2[AW-1:0];
                                state_next   = S_READ;
                            end
                        end
                        FUNC_DROP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                stat_next = ST_UNDER;
                            end
                            else if (cnt_reg == CNT_W'(1))
                            begin
                                cnt_next = '0;
                            end
                            else
                            begin
                                rd_addr_next = cnt_m2[AW-1:0];
                                state_next   = S_READ;
                            end
                        end
                        FUNC_DUP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                stat_next = ST_UNDER;
                            end
                            else if (full)
                            begin
                                stat_next = ST_OVER;
                            end
                            else
                            begin
                                mem_we   = 1'b1;
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        FUNC_DUMP:
                        begin
                            // empty stack: single zero result from S_EMIT
                            if (cnt_reg != '0)
                            begin
                                rd_addr_next = cnt_m1[AW-1:0];
                                state_next   = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                case (func_reg)
                    FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV:
                    begin
                        alu_req.start = 1'b1;
                        state_next    = S_ALU;
                    end
                    FUNC_DROP:
                    begin
                        top_next   = rd_data_reg;
                        cnt_next   = cnt_m1;
                        state_next = S_EMIT;
                    end
                    FUNC_SWAP:
                    begin
                        // old top goes below, second becomes top
                        mem_we     = 1'b1;
                        mem_waddr  = cnt_m2[AW-1:0];
                        mem_wdata  = top_reg;
                        top_next   = rd_data_reg;
                        state_next = S_SWAP;
                    end
                    FUNC_DUMP:
                    begin
                        if (slot_free)
                        begin
                            out_valid_next = 1'b1;
                            value_next     = rd_data_reg;
                            depth_next     = DEPTH_W'(cnt_reg);
                            status_next    = ST_OK;
                            last_next      = (rd_addr_reg == '0);
                            if (rd_addr_reg == '0)
                            begin
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                rd_addr_next = rd_addr_reg - AW'(1);
                                state_next   = S_READ;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_ALU:
            begin
                if (alu_rsp.done)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = cnt_m2[AW-1:0];
                    mem_wdata  = alu_rsp.result;
                    top_next   = alu_rsp.result;
                    cnt_next   = cnt_m1;
                    state_next = S_EMIT;
                end
            end
            S_SWAP:
            begin
                mem_we     = 1'b1;
                mem_waddr  = cnt_m1[AW-1:0];
                mem_wdata  = top_reg;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    value_next     = (cnt_reg == '0) ? '0 : top_reg;
                    depth_next     = DEPTH_W'(cnt_reg);
                    status_next    = stat_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // stack memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg     <= top_next;
        func_reg    <= func_next;
        stat_reg    <= stat_next;
        rd_addr_reg <= rd_addr_next;
        value_reg   <= value_next;
        depth_reg   <= depth_next;
        status_reg  <= status_next;
        last_reg    <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign depth     = depth_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

// ----- tb/tb_rpn_stack_calculator.sv -----
// tb_rpn_stack_calculator: self-checking testbench for the RPN stack calculator.
// Runs directed command rows, then random command sequences, and checks results
// against a built-in stack predictor. Depends on rpn_pkg and rpn_stack_calculator.
`timescale 1ns / 1ps

module tb_rpn_stack_calculator;
    import rpn_pkg::*;

    // unknown command codes sit just above dump
    localparam logic [FUNC_W-1:0] FUNC_UNK_LO = 4'd9;
    localparam logic [FUNC_W-1:0] FUNC_UNK_HI = 4'd15;

    localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [DATA_W-1:0] MOST_POS = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

    localparam int NUM_RANDOM   = 175;
    localparam int MAX_GAP      = 5;
    localparam int DRAIN_CYCLES = 50;       // longer than a div/mul command
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum int {SEQ_MIX, SEQ_FILL} seq_kind_t;

    // one result beat as the block presents it
    typedef struct packed {
        logic [DATA_W-1:0]  value;
        logic [DEPTH_W-1:0] depth;
        logic [STAT_W-1:0]  status;
        logic               last;
    } calc_result_t;

    // one row of the directed table; fixed_exp marks rows whose single
    // result is typed in instead of taken from the predictor
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [DATA_W-1:0]  operand;
        logic               fixed_exp;
        logic [DATA_W-1:0]  value;
        logic [DEPTH_W-1:0] depth;
        logic [STAT_W-1:0]  status;
    } dir_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [FUNC_W-1:0]         func;
    logic signed [DATA_W-1:0]  operand;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [DATA_W-1:0]  value;
    logic [DEPTH_W-1:0]        depth;
    logic [STAT_W-1:0]         status;
    logic                      last;

    // predictor state: shadow stack and entry count
    logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
    int                shadow_count;

    calc_result_t pending_results[$];
    dir_row_t     dir_tbl[$];

    int mismatches;
    int cycle_cnt;
    bit calm;           // when set, neither side idles

    rpn_stack_calculator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .operand   (operand),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value),
        .depth     (depth),
        .status    (status),
        .last      (last)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // run-length guard
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("rpn_stack_calculator: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("ERROR %0t: %s got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic int pick_gap();
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Apply one command to the shadow stack and queue the results it gives.
    // Error cases leave the stack as it was; underflow is tested first.
    task automatic predict_stack_cmd(input logic [FUNC_W-1:0] f,
                                     input logic [DATA_W-1:0] opnd);
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] r;
        logic [STAT_W-1:0] st;
        calc_result_t      res;
        st = ST_OK;
        r  = '0;
        if (f == FUNC_DUMP)
        begin
            // empty dump still gives one beat with last set
            if (shadow_count == 0)
                pending_results.push_back('{'0, '0, ST_OK, 1'b1});
            else
                for (int k = shadow_count - 1; k >= 0; k--)
                    pending_results.push_back('{shadow_stack[k], DEPTH_W'(shadow_count),
                                                ST_OK, (k == 0)});
        end
        else
        begin
            case (f)
                FUNC_PUSH:
                    if (shadow_count >= STACK_DEPTH)
                        st = ST_OVER;
                    else
                    begin
                        shadow_stack[shadow_count] = opnd;
                        shadow_count++;
                    end
                FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV:
                    if (shadow_count < 2)
                        st = ST_UNDER;
                    else
                    begin
                        a = shadow_stack[shadow_count - 1];
                        b = shadow_stack[shadow_count - 2];
                        case (f)
                            FUNC_ADD: r = b + a;
                            FUNC_SUB: r = b - a;
                            FUNC_MUL: r = b * a;
                            default:
                                if (a == '0)
                                    st = ST_DIVZ;
                                else if (b == MOST_NEG && a == ALL_ONES)
                                    r = MOST_NEG;       // quotient wraps
                                else
                                    r = $signed(b) / $signed(a);
                        endcase
                        if (st == ST_OK)
                        begin
                            shadow_stack[shadow_count - 2] = r;
                            shadow_count--;
                        end
                    end
                FUNC_DROP:
                    if (shadow_count < 1)
                        st = ST_UNDER;
                    else
                        shadow_count--;
                FUNC_SWAP:
                    if (shadow_count < 2)
                        st = ST_UNDER;
                    else
                    begin
                        a = shadow_stack[shadow_count - 1];
                        shadow_stack[shadow_count - 1] = shadow_stack[shadow_count - 2];
                        shadow_stack[shadow_count - 2] = a;
                    end
                FUNC_DUP:
                    if (shadow_count < 1)
                        st = ST_UNDER;
                    else if (shadow_count >= STACK_DEPTH)
                        st = ST_OVER;
                    else
                    begin
                        shadow_stack[shadow_count] = shadow_stack[shadow_count - 1];
                        shadow_count++;
                    end
                default: ;      // unknown code: no change, ok status
            endcase
            res.value  = (shadow_count == 0) ? '0 : shadow_stack[shadow_count - 1];
            res.depth  = DEPTH_W'(shadow_count);
            res.status = st;
            res.last   = 1'b1;
            pending_results.push_back(res);
        end
    endtask

    // Present one request after a random gap and hold it until accepted.
    // Entered and left at a falling edge. in_valid is only lowered when a
    // gap follows, so it never drops and rises within one step.
    task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] opnd,
                            input logic fixed_exp, input calc_result_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        operand  <= opnd;
        do
            @(posedge clk);
        while (!in_ready);
        predict_stack_cmd(f, opnd);
        if (fixed_exp)
        begin
            // typed-in expectation replaces the predicted one
            void'(pending_results.pop_back());
            pending_results.push_back(want);
        end
        @(negedge clk);
    endtask

    // operand pool weighted toward the values that hit the corner cases
    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return MOST_NEG;
            3:       return MOST_POS;
            4, 5:    return DATA_W'($signed($urandom_range(0, 40)) - 20);
            default: return $urandom();
        endcase
    endfunction

    // Random command whose mix follows the current depth, so the stack
    // mostly holds a few entries and arithmetic has operands to work on.
    task automatic pick_cmd(output logic [FUNC_W-1:0] f, output logic [DATA_W-1:0] opnd);
        int roll;
        int push_lim;
        roll     = $urandom_range(0, 99);
        push_lim = (shadow_count < 3) ? 55 : (shadow_count > 12) ? 15 : 33;
        opnd     = pick_operand();
        if (roll < 3)
            f = FUNC_W'($urandom_range(FUNC_UNK_LO, FUNC_UNK_HI));
        else if (roll < 3 + push_lim)
            f = FUNC_PUSH;
        else if (roll < 8 + push_lim)
            f = (shadow_count <= 8) ? FUNC_DUMP : FUNC_DROP;
        else
            case ($urandom_range(0, 6))
                0:       f = FUNC_ADD;
                1:       f = FUNC_SUB;
                2:       f = FUNC_MUL;
                3:       f = FUNC_DIV;
                4:       f = FUNC_DROP;
                5:       f = FUNC_SWAP;
                default: f = FUNC_DUP;
            endcase
    endtask

    // output side: random stall before each result beat
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
            @(negedge clk);
        end
    end

    // result checker: every accepted beat against the oldest expectation
    always @(posedge clk)
    begin : result_check
        calc_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending, value", value, '0);
            else
            begin
                exp_r = pending_results.pop_front();
                if (value !== exp_r.value)
                    report_mismatch("value", value, exp_r.value);
                if (depth !== exp_r.depth)
                    report_mismatch("depth", DATA_W'(depth), DATA_W'(exp_r.depth));
                if (status !== exp_r.status)
                    report_mismatch("status", DATA_W'(status), DATA_W'(exp_r.status));
                if (last !== exp_r.last)
                    report_mismatch("last", DATA_W'(last), DATA_W'(exp_r.last));
            end
        end
    end

    // main stimulus
    initial
    begin
        logic [FUNC_W-1:0] f;
        logic [DATA_W-1:0] opnd;
        seq_kind_t         kind;
        dir_row_t          row;
        int                rand_sent;
        int                seq_idx;
        int                seq_len;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = FUNC_PUSH;
        operand      = '0;
        shadow_count = 0;
        mismatches   = 0;
        cycle_cnt    = 0;
        calm         = 1'b0;
        rand_sent    = 0;
        seq_idx      = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part: empty-stack errors, wraparound, divide corners, then a
        // predicted mix with unknown codes, ending in a dump
        dir_tbl.push_back('{FUNC_DUMP, 32'h0,    1'b1, 32'h0,    6'd0, ST_OK});
        dir_tbl.push_back('{FUNC_DROP, 32'h0,    1'b1, 32'h0,    6'd0, ST_UNDER});
        dir_tbl.push_back('{FUNC_ADD,  32'h0,    1'b1, 32'h0,    6'd0, ST_UNDER});
        dir_tbl.push_back('{FUNC_DIV,  32'h0,    1'b1, 32'h0,    6'd0, ST_UNDER});
        dir_tbl.push_back('{FUNC_DUP,  32'h0,    1'b1, 32'h0,    6'd0, ST_UNDER});
        dir_tbl.push_back('{FUNC_SWAP, 32'h0,    1'b1, 32'h0,    6'd0, ST_UNDER});
        dir_tbl.push_back('{FUNC_PUSH, MOST_POS, 1'b1, MOST_POS, 6'd1, ST_OK});
        dir_tbl.push_back('{FUNC_SUB,  32'h0,    1'b1, MOST_POS, 6'd1, ST_UNDER});
        dir_tbl.push_back('{FUNC_SWAP, 32'h0,    1'b1, MOST_POS, 6'd1, ST_UNDER});
        dir_tbl.push_back('{FUNC_PUSH, 32'h1,    1'b1, 32'h1,    6'd2, ST_OK});
        dir_tbl.push_back('{FUNC_ADD,  32'h0,    1'b1, MOST_NEG, 6'd1, ST_OK});
        dir_tbl.push_back('{FUNC_PUSH, ALL_ONES, 1'b1, ALL_ONES, 6'd2, ST_OK});
        dir_tbl.push_back('{FUNC_DIV,  32'h0,    1'b1, MOST_NEG, 6'd1, ST_OK});
        dir_tbl.push_back('{FUNC_PUSH, 32'h0,    1'b1, 32'h0,    6'd2, ST_OK});
        dir_tbl.push_back('{FUNC_DIV,  32'h0,    1'b1, 32'h0,    6'd2, ST_DIVZ});
        dir_tbl.push_back('{FUNC_DROP, 32'h0,    1'b1, MOST_NEG, 6'd1, ST_OK});
        dir_tbl.push_back('{FUNC_PUSH, -32'sd7,  1'b0, 32'h0,    6'd0, ST_OK});
        dir_tbl.push_back('{FUNC_PUSH, 32'h2,    1'b0, 32'h0,    6'd0, ST_OK});
        dir_tbl.push_back('{FUNC_DIV,  32'h0,    1'b0, 32'h0,    6'd0, ST_OK});
        dir_tbl.push_back('{FUNC_SWAP, 32'h0,    1'b0, 32'h0,    6'd0, ST_OK});
        dir_tbl.push_back('{FUNC_SUB,  32'h0,    1'b0, 32'h0,    6'd0, ST_OK});
        dir_tbl.push_back('{FUNC_DUP,  32'h0,    1'b0, 32'h0,    6'd0, ST_OK});
        dir_tbl.push_back('{FUNC_MUL,  32'h0,    1'b0, 32'h0,    6'd0, ST_OK});
        dir_tbl.push_back('{FUNC_UNK_LO, ALL_ONES, 1'b0, 32'h0,  6'd0, ST_OK});
        dir_tbl.push_back('{FUNC_UNK_HI, 32'h0,  1'b0, 32'h0,    6'd0, ST_OK});
        dir_tbl.push_back('{FUNC_DUMP, 32'h0,    1'b0, 32'h0,    6'd0, ST_OK});

        foreach (dir_tbl[i])
        begin
            row = dir_tbl[i];
            send_cmd(row.func, row.operand, row.fixed_exp,
                     '{row.value, row.depth, row.status, 1'b1});
        end

        // random part: mostly mixed sequences; fill runs take the stack to
        // full, hit overflow on push and dup, dump all entries, then drain
        while (rand_sent < NUM_RANDOM)
        begin
            calm = ($urandom_range(0, 3) == 0);
            kind = (seq_idx == 2 || $urandom_range(0, 24) == 0) ? SEQ_FILL : SEQ_MIX;
            seq_idx++;
            if (kind == SEQ_FILL)
            begin
                while (shadow_count < STACK_DEPTH)
                begin
                    send_cmd(FUNC_PUSH, pick_operand(), 1'b0, '0);
                    rand_sent++;
                end
                send_cmd(FUNC_PUSH, pick_operand(), 1'b0, '0);
                send_cmd(FUNC_DUP,  '0, 1'b0, '0);
                send_cmd(FUNC_DUMP, '0, 1'b0, '0);
                send_cmd(FUNC_SWAP, '0, 1'b0, '0);
                rand_sent += 4;
                while (shadow_count > 4)
                begin
                    case ($urandom_range(0, 4))
                        0:       f = FUNC_ADD;
                        1:       f = FUNC_SUB;
                        2:       f = FUNC_MUL;
                        3:       f = FUNC_DIV;
                        default: f = FUNC_DROP;
                    endcase
                    send_cmd(f, '0, 1'b0, '0);
                    rand_sent++;
                end
            end
            else
            begin
                seq_len = $urandom_range(6, 18);
                repeat (seq_len)
                begin
                    pick_cmd(f, opnd);
                    send_cmd(f, opnd, 1'b0, '0);
                    rand_sent++;
                end
            end
        end

        in_valid <= 1'b0;
        calm = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("rpn_stack_calculator: match");
        else
            $display("rpn_stack_calculator: mismatch");
        $finish;
    end

endmodule
